FILE: rtl/core/bp2rgb_pkg.sv
// Shared types, constants and colour widening for the bitplane to RGB555 converter.
// Used by every module in rtl/core; depends on nothing.
`timescale 1ns / 1ps

package bp2rgb_pkg;

    localparam int GROUP_PIXELS = 16;
    localparam int PLANES       = 4;
    localparam int PENS         = 16;
    localparam int PEN_W        = 4;
    localparam int POS_W        = 4;
    localparam int RGB_W        = 15;
    localparam int VAL_W        = 12;
    localparam int LEFT_W       = $clog2(GROUP_PIXELS + 1);

    localparam logic FUNC_PAL_WRITE = 1'b0;
    localparam logic FUNC_GROUP     = 1'b1;

    typedef struct packed {
        logic             func;
        logic [15:0]      plane0;
        logic [15:0]      plane1;
        logic [15:0]      plane2;
        logic [15:0]      plane3;
        logic [PEN_W-1:0] pal_index;
        logic [VAL_W-1:0] pal_value;
    } t_in_item;

    typedef struct packed {
        logic [PEN_W-1:0] pen;
        logic [RGB_W-1:0] color;
        logic [POS_W-1:0] pixel_pos;
        logic             last;
    } t_out_item;

    // Palette write request into the colour store
    typedef struct packed {
        logic             en;
        logic [PEN_W-1:0] idx;
        logic [VAL_W-1:0] value;
    } t_pal_wr;

    // Per-cycle control for the row of pixel cells
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    // c * 31 / 7, truncated, for a 3-bit channel
    function automatic logic [4:0] widen3to5(input logic [2:0] c);
        logic [4:0] v;
        case (c)
            3'd0:    v = 5'd0;
            3'd1:    v = 5'd4;
            3'd2:    v = 5'd8;
            3'd3:    v = 5'd13;
            3'd4:    v = 5'd17;
            3'd5:    v = 5'd22;
            3'd6:    v = 5'd26;
            3'd7:    v = 5'd31;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

    function automatic logic [RGB_W-1:0] to_rgb555(input logic [VAL_W-1:0] w);
        return {widen3to5(w[10:8]), widen3to5(w[6:4]), widen3to5(w[2:0])};
    endfunction

endpackage

FILE: rtl/core/bp2rgb_cell.sv
// One pixel cell of the shifter row: holds a 4-bit pen and passes it to its left neighbour.
// Depends on bp2rgb_pkg.
`timescale 1ns / 1ps

module bp2rgb_cell (
    input  logic                        i_clk,
    input  bp2rgb_pkg::t_cell_ctl       i_ctl,
    input  logic [bp2rgb_pkg::PEN_W-1:0] i_load_pen,
    input  logic [bp2rgb_pkg::PEN_W-1:0] i_next_pen,
    output logic [bp2rgb_pkg::PEN_W-1:0] o_pen
);

    logic [bp2rgb_pkg::PEN_W-1:0] r_pen;

    // load a fresh column, otherwise take the right neighbour's pen on a shift
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_pen <= i_load_pen;
        end else if (i_ctl.shift) begin
            r_pen <= i_next_pen;
        end
    end

    assign o_pen = r_pen;

endmodule

FILE: rtl/core/bp2rgb_palette.sv
// Sixteen-entry RGB555 colour store, widened from 3-bit channels on write.
// Depends on bp2rgb_pkg.
`timescale 1ns / 1ps

module bp2rgb_palette (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bp2rgb_pkg::t_pal_wr          i_wr,
    input  logic [bp2rgb_pkg::PEN_W-1:0] i_rd_pen,
    output logic [bp2rgb_pkg::RGB_W-1:0] o_rd_color
);

    logic [bp2rgb_pkg::RGB_W-1:0] r_pal [bp2rgb_pkg::PENS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < bp2rgb_pkg::PENS; k++) begin
                r_pal[k] <= '0;
            end
        end else if (i_wr.en) begin
            r_pal[i_wr.idx] <= bp2rgb_pkg::to_rgb555(i_wr.value);
        end
    end

    assign o_rd_color = r_pal[i_rd_pen];

endmodule

FILE: rtl/core/bitplane_to_rgb555_pixel_converter.sv
// Top level of the 4-bitplane low-res to RGB555 pixel converter.
// Depends on bp2rgb_pkg, bp2rgb_cell and bp2rgb_palette.
`timescale 1ns / 1ps

// A group transaction (func = 1) loads its four plane words into a row of
// sixteen pixel cells, one 4-bit pen per cell, leftmost pixel in cell 0.
// The row shifts one cell left per clock unless the output stalls; the pen
// leaving cell 0 is looked up in the colour store and registered as one
// output transaction, so a group yields sixteen pixels, one pixel per clock.
// The next group is taken in the cycle the last pixel leaves the row, so
// groups follow one another with no gap while the output does not stall.
// A palette write (func = 0) yields no output; it is accepted only once
// the row has drained or as its last pixel leaves, so every pixel of a
// group sees the palette as it stood when the group arrived. Output
// stalls hold the row; the output register lets the row refill while a
// pixel waits. The colour store clears to zero on reset.

module bitplane_to_rgb555_pixel_converter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  bp2rgb_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output bp2rgb_pkg::t_out_item o_out_data
);

    localparam int PIX = bp2rgb_pkg::GROUP_PIXELS;
    localparam int LW  = bp2rgb_pkg::LEFT_W;
    localparam int PW  = bp2rgb_pkg::PEN_W;

    logic [LW-1:0]               r_left;
    logic [LW-1:0]               n_left;
    logic                        r_out_valid;
    logic                        n_out_valid;
    bp2rgb_pkg::t_out_item       r_out;
    bp2rgb_pkg::t_out_item       n_out;

    logic                        w_accept;
    logic                        w_advance;
    bp2rgb_pkg::t_cell_ctl       w_ctl;
    bp2rgb_pkg::t_pal_wr         w_wr;
    logic [bp2rgb_pkg::RGB_W-1:0] w_color;
    logic [PW-1:0]               w_pen [PIX+1];

    // advance the row whenever a pixel remains and the output register frees
    assign w_advance  = (r_left != '0) && (!r_out_valid || i_out_ready);
    // take a transaction when the row is empty or its last pixel leaves now
    assign o_in_ready = (r_left == '0) || ((r_left == LW'(1)) && w_advance);
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_ctl.load  = w_accept && (i_in_data.func == bp2rgb_pkg::FUNC_GROUP);
    assign w_ctl.shift = w_advance;

    assign w_wr.en    = w_accept && (i_in_data.func == bp2rgb_pkg::FUNC_PAL_WRITE);
    assign w_wr.idx   = i_in_data.pal_index;
    assign w_wr.value = i_in_data.pal_value;

    // the cell beyond the right end feeds zeros
    assign w_pen[PIX] = '0;

    for (genvar k = 0; k < PIX; k++) begin : g_cell
        bp2rgb_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_load_pen ({i_in_data.plane3[PIX-1-k], i_in_data.plane2[PIX-1-k],
                          i_in_data.plane1[PIX-1-k], i_in_data.plane0[PIX-1-k]}),
            .i_next_pen (w_pen[k+1]),
            .o_pen      (w_pen[k])
        );
    end

    bp2rgb_palette u_palette (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_wr),
        .i_rd_pen   (w_pen[0]),
        .o_rd_color (w_color)
    );

    always_comb begin
        n_left      = r_left;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_advance) begin
            n_left          = r_left - LW'(1);
            n_out_valid     = 1'b1;
            n_out.pen       = w_pen[0];
            n_out.color     = w_color;
            // position counts up as the remaining count runs down
            n_out.pixel_pos = bp2rgb_pkg::POS_W'(LW'(PIX) - r_left);
            n_out.last      = (r_left == LW'(1));
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_ctl.load) begin
            n_left = LW'(PIX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/core/bp2rgb_chk.sv
// Port-level checker for the bitplane to RGB555 converter, bound to the top level.
// Depends on bp2rgb_pkg.
`timescale 1ns / 1ps

module bp2rgb_chk (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input bp2rgb_pkg::t_in_item  i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input bp2rgb_pkg::t_out_item o_out_data
);

    // hold a stalled output transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output transaction dropped while stalled");

    // pixels of one group leave without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.last |=> o_out_valid)
        else $error("gap inside a pixel group");

    // position advances by one within a group
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.last |=>
        o_out_data.pixel_pos == $past(o_out_data.pixel_pos) + 4'd1)
        else $error("pixel position did not advance");

    // last marks position 15 only
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last == (o_out_data.pixel_pos == 4'd15)))
        else $error("last flag and position disagree");

    // no new transaction while at least two pixels are still in the row
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.pixel_pos < 4'd14) |-> !o_in_ready)
        else $error("input taken while a group is still shifting");

endmodule

bind bitplane_to_rgb555_pixel_converter bp2rgb_chk u_bp2rgb_chk (.*);
